[design/vtyp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, side-band types and angle helpers for the yaw/pitch converter.
package vtyp_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;

  // Coordinate width holds 2^39 inputs grown by the CORDIC gain and the diagonal.
  localparam int CW    = 44;
  // Angle accumulator in 1/65536 degree, covering -100 to +280 degrees.
  localparam int AW    = 27;
  localparam int AT_W  = 22;
  localparam int ANG_W = 17;
  localparam int PIT_W = 18;
  localparam int MAG_W = 24;
  localparam int VEC_W = 16;
  localparam int SQ_W  = 31;

  localparam logic [ANG_W-1:0] ANG_TURN          = 17'd92160;
  localparam logic [ANG_W-1:0] ANG_QUARTER       = 17'd23040;
  localparam logic [ANG_W-1:0] ANG_THREE_QUARTER = 17'd69120;
  localparam logic signed [AW-1:0] ACC_HALF_TURN = 27'sd11796480;
  localparam logic signed [AW-1:0] ACC_ROUND     = 27'sd128;
  localparam logic signed [AW-8:0] TURN_WIDE     = 20'sd92160;

  typedef struct packed {
    logic [2*VEC_W-1:0]        mag2;
    logic signed [VEC_W-1:0]   z;
    logic                      xy_zero;
    logic                      x_zero;
    logic                      y_pos;
    logic                      z_pos;
  } yaw_side_t;

  typedef struct packed {
    logic [ANG_W-1:0]          yaw;
    logic signed [VEC_W-1:0]   z;
    logic                      xy_zero;
    logic                      z_pos;
  } sqrt_side_t;

  typedef struct packed {
    logic [ANG_W-1:0] yaw;
    logic             xy_zero;
    logic             z_pos;
  } pitch_side_t;

  // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
  function automatic logic [AT_W-1:0] atan_step(input int unsigned idx);
    logic [AT_W-1:0] v;
    case (idx)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round to 1/256 degree (floor of acc + 128 over 256) and wrap into one turn.
  function automatic logic [ANG_W-1:0] fold_angle(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] biased;
    logic signed [AW-8:0] w;
    biased = acc + ACC_ROUND;
    w = {biased[AW-1], biased[AW-1:8]};
    if (w < 0) begin
      w = w + TURN_WIDE;
    end else if (w >= TURN_WIDE) begin
      w = w - TURN_WIDE;
    end
    return w[ANG_W-1:0];
  endfunction

endpackage

[design/vtyp_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined restoring integer square root, one root bit per stage.
module vtyp_sqrt #(
  parameter int RW = vtyp_pkg::MAG_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);
  logic [2*RW-1:0] rem    [0:RW];
  logic [RW-1:0]   root   [0:RW];
  logic [SW-1:0]   side_s [0:RW];
  logic            vld    [0:RW];

  assign rem[0]    = in_rad;
  assign root[0]   = '0;
  assign side_s[0] = in_side;
  assign vld[0]    = in_valid;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int K = RW - 1 - j;
    logic [2*RW-1:0] cand;

    // Trial value is (2*root + 2^K) * 2^K with root holding only bits above K.
    assign cand = ({{RW{1'b0}}, root[j]} << (K + 1)) | ((2*RW)'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (advance) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        side_s[j+1] <= side_s[j];
        if (rem[j] >= cand) begin
          rem[j+1]  <= rem[j] - cand;
          root[j+1] <= root[j] | (RW'(1) << K);
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j];
        end
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_side  = side_s[RW];

`ifndef SYNTHESIS
  // A floor square root leaves a remainder of at most twice the root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[RW] |-> rem[RW] <= (2*RW)'({root[RW], 1'b0}))
    else $error("square root remainder exceeds twice the root");
`endif

endmodule

[design/vtyp_cordic.sv]
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring unit, one micro-rotation per register stage.
module vtyp_cordic #(
  parameter int STAGES = vtyp_pkg::CORDIC_STAGES_DEF,
  parameter int SW     = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           in_valid,
  input  logic signed [vtyp_pkg::CW-1:0] in_x,
  input  logic signed [vtyp_pkg::CW-1:0] in_y,
  input  logic signed [vtyp_pkg::AW-1:0] in_acc,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic signed [vtyp_pkg::AW-1:0] out_acc,
  output logic [SW-1:0]                  out_side
);
  import vtyp_pkg::*;

  // Stages beyond the angle table add nothing, so the count is capped there.
  localparam int N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

  logic signed [CW-1:0] xs     [0:N];
  logic signed [CW-1:0] ys     [0:N];
  logic signed [AW-1:0] acc_s  [0:N];
  logic [SW-1:0]        side_s [0:N];
  logic                 vld    [0:N];

  assign xs[0]     = in_x;
  assign ys[0]     = in_y;
  assign acc_s[0]  = in_acc;
  assign side_s[0] = in_side;
  assign vld[0]    = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [AW-1:0] ang;

    // Arithmetic shifts round toward minus infinity, as the rotation needs.
    assign x_sh = xs[i] >>> i;
    assign y_sh = ys[i] >>> i;
    assign ang  = signed'({{(AW-AT_W){1'b0}}, atan_step(unsigned'(i))});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        side_s[i+1] <= side_s[i];
        if (!ys[i][CW-1]) begin
          xs[i+1]    <= xs[i] + y_sh;
          ys[i+1]    <= ys[i] - x_sh;
          acc_s[i+1] <= acc_s[i] + ang;
        end else begin
          xs[i+1]    <= xs[i] - y_sh;
          ys[i+1]    <= ys[i] + x_sh;
          acc_s[i+1] <= acc_s[i] - ang;
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_acc   = acc_s[N];
  assign out_side  = side_s[N];

endmodule

[design/vector_to_yaw_pitch.sv]
`timescale 1ns / 1ps
// Top level: direction vector to yaw and negated pitch through two CORDIC passes.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid, in_ready  | vec_x, vec_y, vec_z (16 bit signed)
//   output  | out_valid, out_ready| yaw_angle (17 bit), pitch_angle (18 bit)
//
// One vector is taken every cycle unless the output stalls. A vector passes two
// input stages, the yaw CORDIC, 24 square-root stages, the pitch CORDIC
// and the output register. The whole pipeline moves on one advance signal,
// which is low only while a result sits in the output register and out_ready
// is low. Reset clears the valid bits; no data is lost or repeated on a stall.
module vector_to_yaw_pitch #(
  parameter int CORDIC_STAGES = vtyp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vtyp_pkg::VEC_W-1:0]    vec_x,
  input  logic signed [vtyp_pkg::VEC_W-1:0]    vec_y,
  input  logic signed [vtyp_pkg::VEC_W-1:0]    vec_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vtyp_pkg::ANG_W-1:0]           yaw_angle,
  output logic signed [vtyp_pkg::PIT_W-1:0]    pitch_angle
);
  import vtyp_pkg::*;

  logic advance;

  // First stage: captured vector.
  logic                    p1_valid;
  logic signed [VEC_W-1:0] p1_x;
  logic signed [VEC_W-1:0] p1_y;
  logic signed [VEC_W-1:0] p1_z;

  // Second stage: squares, yaw start point and flags.
  logic                      p2_valid;
  logic [SQ_W-1:0]           p2_xsq;
  logic [SQ_W-1:0]           p2_ysq;
  logic signed [CW-1:0]      p2_yx;
  logic signed [CW-1:0]      p2_yy;
  logic signed [AW-1:0]      p2_acc;
  logic signed [VEC_W-1:0]   p2_z;
  logic                      p2_xy_zero;
  logic                      p2_x_zero;
  logic                      p2_y_pos;
  logic                      p2_z_pos;

  logic signed [2*VEC_W-1:0] x_prod;
  logic signed [2*VEC_W-1:0] y_prod;
  logic signed [VEC_W:0]     sx;
  logic signed [VEC_W:0]     sy;
  logic signed [VEC_W:0]     ax;
  logic signed [VEC_W:0]     ay;

  yaw_side_t            yc_side_in;
  yaw_side_t            yc_side_out;
  logic                 yc_valid;
  logic signed [AW-1:0] yc_acc;
  logic [ANG_W-1:0]     yaw_sel;

  sqrt_side_t           sq_side_in;
  sqrt_side_t           sq_side_out;
  logic                 sq_valid;
  logic [MAG_W-1:0]     sq_root;

  pitch_side_t          pc_side_in;
  pitch_side_t          pc_side_out;
  logic                 pc_valid;
  logic signed [AW-1:0] pc_acc;
  logic signed [CW-1:0] pc_x0;
  logic signed [CW-1:0] pc_y0;

  logic [ANG_W-1:0]        pitch_pos;
  logic signed [PIT_W-1:0] pitch_neg;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (advance) begin
      p1_valid <= in_valid;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_x <= vec_x;
      p1_y <= vec_y;
      p1_z <= vec_z;
    end
  end

  assign x_prod = p1_x * p1_x;
  assign y_prod = p1_y * p1_y;
  assign sx     = {p1_x[VEC_W-1], p1_x};
  assign sy     = {p1_y[VEC_W-1], p1_y};
  // The left half plane is turned through 180 degrees before the yaw pass.
  assign ax     = p1_x[VEC_W-1] ? -sx : sx;
  assign ay     = p1_x[VEC_W-1] ? -sy : sy;

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_xsq     <= x_prod[SQ_W-1:0];
      p2_ysq     <= y_prod[SQ_W-1:0];
      p2_yx      <= {{(CW-VEC_W-25){ax[VEC_W]}}, ax, 24'b0};
      p2_yy      <= {{(CW-VEC_W-25){ay[VEC_W]}}, ay, 24'b0};
      p2_acc     <= p1_x[VEC_W-1] ? ACC_HALF_TURN : '0;
      p2_z       <= p1_z;
      p2_xy_zero <= (p1_x == '0) && (p1_y == '0);
      p2_x_zero  <= (p1_x == '0);
      p2_y_pos   <= !p1_y[VEC_W-1] && (p1_y != '0);
      p2_z_pos   <= !p1_z[VEC_W-1] && (p1_z != '0);
    end
  end

  assign yc_side_in.mag2    = (2*VEC_W)'(p2_xsq) + (2*VEC_W)'(p2_ysq);
  assign yc_side_in.z       = p2_z;
  assign yc_side_in.xy_zero = p2_xy_zero;
  assign yc_side_in.x_zero  = p2_x_zero;
  assign yc_side_in.y_pos   = p2_y_pos;
  assign yc_side_in.z_pos   = p2_z_pos;

  vtyp_cordic #(
    .STAGES (CORDIC_STAGES),
    .SW     ($bits(yaw_side_t))
  ) u_yaw_cordic (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (p2_valid),
    .in_x      (p2_yx),
    .in_y      (p2_yy),
    .in_acc    (p2_acc),
    .in_side   (yc_side_in),
    .out_valid (yc_valid),
    .out_acc   (yc_acc),
    .out_side  (yc_side_out)
  );

  // On the y axis the yaw is exact; at the origin it is zero.
  always_comb begin
    if (yc_side_out.xy_zero) begin
      yaw_sel = '0;
    end else if (yc_side_out.x_zero) begin
      yaw_sel = yc_side_out.y_pos ? ANG_QUARTER : ANG_THREE_QUARTER;
    end else begin
      yaw_sel = fold_angle(yc_acc);
    end
  end

  assign sq_side_in.yaw     = yaw_sel;
  assign sq_side_in.z       = yc_side_out.z;
  assign sq_side_in.xy_zero = yc_side_out.xy_zero;
  assign sq_side_in.z_pos   = yc_side_out.z_pos;

  // The radicand carries 16 extra fraction bits, giving 8 on the magnitude.
  vtyp_sqrt #(
    .RW (MAG_W),
    .SW ($bits(sqrt_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (yc_valid),
    .in_rad    ({yc_side_out.mag2, 16'b0}),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  assign pc_x0 = {{(CW-MAG_W-16){1'b0}}, sq_root, 16'b0};
  assign pc_y0 = {{(CW-VEC_W-24){sq_side_out.z[VEC_W-1]}}, sq_side_out.z, 24'b0};

  assign pc_side_in.yaw     = sq_side_out.yaw;
  assign pc_side_in.xy_zero = sq_side_out.xy_zero;
  assign pc_side_in.z_pos   = sq_side_out.z_pos;

  vtyp_cordic #(
    .STAGES (CORDIC_STAGES),
    .SW     ($bits(pitch_side_t))
  ) u_pitch_cordic (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sq_valid),
    .in_x      (pc_x0),
    .in_y      (pc_y0),
    .in_acc    ('0),
    .in_side   (pc_side_in),
    .out_valid (pc_valid),
    .out_acc   (pc_acc),
    .out_side  (pc_side_out)
  );

  // Straight up or down when there is no horizontal component.
  always_comb begin
    if (pc_side_out.xy_zero) begin
      pitch_pos = pc_side_out.z_pos ? ANG_QUARTER : ANG_THREE_QUARTER;
    end else begin
      pitch_pos = fold_angle(pc_acc);
    end
  end

  assign pitch_neg = -signed'({1'b0, pitch_pos});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      yaw_angle   <= pc_side_out.yaw;
      pitch_angle <= pitch_neg;
    end
  end

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> yaw_angle < ANG_TURN)
    else $error("yaw angle outside one turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 0) && (pitch_angle > -signed'({1'b0, ANG_TURN})))
    else $error("negated pitch angle outside one turn");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(yc_valid) && $stable(sq_valid) && $stable(pc_valid))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for vector_to_yaw_pitch with a queue-fed driver and a monitor.
module tb;
  import vtyp_pkg::*;

  localparam int STAGES  = 16;
  localparam int LATENCY = 27 + 2 * STAGES;
  localparam int LIMIT   = 400000;
  localparam int N_RANDOM = 1150;
  localparam longint SCALE_XY  = 64'sd16777216;
  localparam longint SCALE_MAG = 64'sd65536;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_item_t;

  typedef struct packed {
    logic [ANG_W-1:0]        yaw;
    logic signed [PIT_W-1:0] pitch;
  } angles_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic signed [VEC_W-1:0] vec_x = '0;
  logic signed [VEC_W-1:0] vec_y = '0;
  logic signed [VEC_W-1:0] vec_z = '0;
  logic in_ready;
  logic out_valid;
  logic [ANG_W-1:0] yaw_angle;
  logic signed [PIT_W-1:0] pitch_angle;

  vec_item_t pending[$];
  angles_t   angles_due[$];
  int unsigned sent_count = 0;
  int unsigned cycles = 0;
  int failures = 0;
  idle_mode_t idle_mode;

  // Micro-rotation angles atan(2^-i) in 1/65536 degree.
  longint atan_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  vector_to_yaw_pitch #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .yaw_angle(yaw_angle),
    .pitch_angle(pitch_angle)
  );

  always #6 clk = ~clk;

  // Idling regime changes every 96 transfers, cycling through all four.
  assign idle_mode = idle_mode_t'((sent_count / 96) % 4);

  function automatic bit rolls_idle(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Vectoring pass: drives cy towards zero and accumulates the rotation angle.
  function automatic longint vector_angle(longint cx, longint cy, longint acc);
    longint xs;
    longint ys;
    int n;
    int i;
    n = (STAGES > 24) ? 24 : STAGES;
    for (i = 0; i < n; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx = cx + ys;
        cy = cy - xs;
        acc = acc + atan_q16[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        acc = acc - atan_q16[i];
      end
    end
    return acc;
  endfunction

  function automatic longint wrap_turn(longint acc);
    longint r;
    r = (acc + 128) >>> 8;
    if (r < 0) r = r + longint'(ANG_TURN);
    if (r >= longint'(ANG_TURN)) r = r - longint'(ANG_TURN);
    return r;
  endfunction

  function automatic angles_t predict_angles(logic signed [VEC_W-1:0] vx,
                                             logic signed [VEC_W-1:0] vy,
                                             logic signed [VEC_W-1:0] vz);
    longint x;
    longint y;
    longint z;
    longint yaw;
    longint pit;
    longint unsigned mag;
    angles_t a;
    x = vx;
    y = vy;
    z = vz;
    if (x == 0 && y == 0) begin
      yaw = 0;
      pit = (z > 0) ? longint'(ANG_QUARTER) : longint'(ANG_THREE_QUARTER);
    end else begin
      if (x == 0) begin
        yaw = (y > 0) ? longint'(ANG_QUARTER) : longint'(ANG_THREE_QUARTER);
      end else if (x < 0) begin
        // Left half plane: mirror through the origin and start from 180 degrees.
        yaw = wrap_turn(vector_angle(-x * SCALE_XY, -y * SCALE_XY, longint'(ACC_HALF_TURN)));
      end else begin
        yaw = wrap_turn(vector_angle(x * SCALE_XY, y * SCALE_XY, 0));
      end
      mag = floor_sqrt(longint'(x * x + y * y) << 16);
      pit = wrap_turn(vector_angle(longint'(mag) * SCALE_MAG, z * SCALE_XY, 0));
    end
    a.yaw = yaw[ANG_W-1:0];
    a.pitch = PIT_W'(-pit);
    return a;
  endfunction

  function automatic logic signed [VEC_W-1:0] corner_value();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic logic signed [VEC_W-1:0] tiny_value();
    return VEC_W'($signed($urandom_range(15)) - 8);
  endfunction

  task automatic add_vec(int x, int y, int z);
    vec_item_t v;
    v.x = VEC_W'(x);
    v.y = VEC_W'(y);
    v.z = VEC_W'(z);
    pending.push_back(v);
  endtask

  // Driver: a new vector is presented only once the previous one has been transferred.
  always @(posedge clk) begin : drive
    vec_item_t nxt;
    int pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        angles_due.push_back(predict_angles(vec_x, vec_y, vec_z));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        pct = (idle_mode == IDLE_SENDER) ? 72 : (idle_mode == IDLE_BOTH) ? 19 : 0;
        if (pending.size() != 0 && !rolls_idle(pct)) begin
          nxt = pending.pop_front();
          in_valid <= 1'b1;
          vec_x <= nxt.x;
          vec_y <= nxt.y;
          vec_z <= nxt.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each transfer on the output against the oldest prediction.
  always @(posedge clk) begin : watch
    angles_t want;
    int pct;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (angles_due.size() == 0) begin
          $error("unexpected result: yaw_angle %0d pitch_angle %0d", yaw_angle, pitch_angle);
          failures++;
        end else begin
          want = angles_due.pop_front();
          if (yaw_angle !== want.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", want.yaw, yaw_angle);
            failures++;
          end
          if (pitch_angle !== want.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", want.pitch, pitch_angle);
            failures++;
          end
        end
      end
      pct = (idle_mode == IDLE_RECEIVER) ? 72 : (idle_mode == IDLE_BOTH) ? 19 : 0;
      out_ready <= !rolls_idle(pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("vector_to_yaw_pitch test failed");
      $finish;
    end
  end

  initial begin
    vec_item_t v;
    int sel;
    int unsigned total_items;
    // Vertical vectors, including the zero vector.
    add_vec(0, 0, 0);
    add_vec(0, 0, 1);
    add_vec(0, 0, -1);
    add_vec(0, 0, 32767);
    add_vec(0, 0, -32768);
    // On the y axis yaw is exactly 90 or 270 degrees.
    add_vec(0, 5, 7);
    add_vec(0, -5, -7);
    add_vec(0, 32767, 0);
    add_vec(0, -32768, 100);
    add_vec(1, 0, 0);
    add_vec(-1, 0, 0);
    add_vec(-5, 0, 3);
    add_vec(-3, 1, -1);
    add_vec(1, 1, 0);
    // Angles just below a full turn that round to 360 and wrap to zero.
    add_vec(32767, -1, 0);
    add_vec(32767, 0, -1);
    add_vec(-32768, -32768, -32768);
    add_vec(32767, 32767, 32767);
    add_vec(-32768, 32767, 0);
    add_vec(32767, -32768, -1);
    add_vec(-32768, 0, 32767);
    add_vec(-32768, -1, 1);

    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(9);
      v.x = VEC_W'($urandom);
      v.y = VEC_W'($urandom);
      v.z = VEC_W'($urandom);
      case (sel)
        5: begin
          v.x = tiny_value();
          v.y = tiny_value();
          v.z = tiny_value();
        end
        6: begin
          if ($urandom_range(1)) v.x = '0;
          else v.y = '0;
        end
        7: begin
          v.x = corner_value();
          v.y = corner_value();
          v.z = corner_value();
        end
        8: begin
          v.x = '0;
          v.y = '0;
        end
        9: begin
          v.x = corner_value();
          v.y = tiny_value();
          v.z = tiny_value();
        end
        default: ;
      endcase
      pending.push_back(v);
    end
    total_items = pending.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Every vector must have been transferred in and its result checked.
    while (sent_count != total_items || angles_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (failures == 0) begin
      $display("vector_to_yaw_pitch test passed");
    end else begin
      $display("vector_to_yaw_pitch test failed");
    end
    $finish;
  end

endmodule
